// ===== hdl/rcct_pkg.sv =====
// Shared types and constants for the ray/cell collision time block.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps

package rcct_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int MAX_GRID_WIDTH = 4096;

  localparam int IDX_W   = 24;                        // flat cell index
  localparam int GW_W    = 13;                        // grid width register
  localparam int COL_W   = $clog2(MAX_GRID_WIDTH);    // column / remainder
  localparam int CS_W    = 31;                        // cell size registers
  localparam int POS_W   = 32;                        // positions, velocities
  localparam int TIME_W  = 31;                        // hit time
  localparam int NUM_W   = 57;                        // time numerator magnitude
  localparam int REM_W   = 32;                        // divider remainder
  localparam int SAT_SH  = TIME_W - FRAC_BITS;        // saturation shift
  localparam int CFG_IDX_W = 2;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd2;

  typedef struct packed {
    logic        [IDX_W-1:0] cell_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] hit_time;
    logic              hit;
  } out_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
  } motion_t;

  // One stage of the index divider chain: dq shifts dividend bits out at the
  // top and quotient bits in at the bottom.
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] rem;
    logic [IDX_W-1:0] dq;
    motion_t          mot;
  } idx_stage_t;

  // One lane of the time divider.
  typedef struct packed {
    logic              hit;
    logic              sat;
    logic [REM_W-1:0]  rem;
    logic [TIME_W-1:0] dq;
    logic [REM_W-1:0]  dvs;
  } tlane_t;

  // Horizontal edges divide by |vel_y|, vertical edges by |vel_x|.
  typedef struct packed {
    logic   valid;
    tlane_t h;
    tlane_t v;
  } tstage_t;

endpackage

// ===== hdl/rcct_idx_cell.sv =====
// One restoring-division cell of the cell index splitter (one quotient bit).
// Depends on rcct_pkg.
`timescale 1ns / 1ps

module rcct_idx_cell import rcct_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [GW_W-1:0]  divisor,
  input  idx_stage_t       stage_i,
  output idx_stage_t       stage_o
);

  logic [GW_W-1:0] part;
  logic [GW_W:0]   diff;
  logic            take;
  idx_stage_t      stage_r;
  idx_stage_t      stage_nxt;

  always_comb begin
    part = {stage_i.rem, stage_i.dq[IDX_W-1]};
    diff = {1'b0, part} - {1'b0, divisor};
    take = ~diff[GW_W];
    stage_nxt     = stage_i;
    stage_nxt.rem = take ? diff[COL_W-1:0] : part[COL_W-1:0];
    stage_nxt.dq  = {stage_i.dq[IDX_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

// ===== hdl/rcct_time_cell.sv =====
// One cell of the two-lane hit time divider: one quotient bit per lane.
// Depends on rcct_pkg.
`timescale 1ns / 1ps

module rcct_time_cell import rcct_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  tstage_t stage_i,
  output tstage_t stage_o
);

  tstage_t stage_r;
  tstage_t stage_nxt;

  function automatic tlane_t div_step(input tlane_t l);
    logic [REM_W:0]   part;
    logic [REM_W+1:0] diff;
    tlane_t           r;
    part = {l.rem, l.dq[TIME_W-1]};
    diff = {1'b0, part} - {2'b0, l.dvs};
    r = l;
    r.rem = diff[REM_W+1] ? part[REM_W-1:0] : diff[REM_W-1:0];
    r.dq  = {l.dq[TIME_W-2:0], ~diff[REM_W+1]};
    return r;
  endfunction

  always_comb begin
    stage_nxt.valid = stage_i.valid;
    stage_nxt.h     = div_step(stage_i.h);
    stage_nxt.v     = div_step(stage_i.v);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

// ===== hdl/rcct_geom.sv =====
// Cell geometry and exact edge tests: corners, cross products split into
// 32-bit partial products, edge decisions, divider setup. Depends on rcct_pkg.
`timescale 1ns / 1ps

module rcct_geom import rcct_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic [CS_W-1:0] cell_size_x,
  input  logic [CS_W-1:0] cell_size_y,
  input  idx_stage_t      stage_i,
  output tstage_t         stage_o
);

  typedef struct packed {
    logic             tb, tt, tl, tr;   // ray parameter sign test per edge
    logic             vx_neg, vy_neg, vx_nz, vy_nz;
    logic [NUM_W-1:0] n_ab, n_at, n_e, n_br;
    logic [REM_W-1:0] avx, avy;
  } side_t;

  // G1: corners
  logic                    v1_r;
  logic [COL_W+CS_W-1:0]   xl1_r, xl1_nxt;
  logic [IDX_W+CS_W-1:0]   yb1_r, yb1_nxt;
  motion_t                 mot1_r;
  // G2: offsets from the lower-left corner
  logic                    v2_r;
  logic signed [44:0]      e2_r, e2_nxt;
  logic signed [56:0]      ab2_r, ab2_nxt;
  logic signed [POS_W-1:0] vx2_r, vy2_r;
  // G3: partial products
  logic                    v3_r;
  logic signed [64:0]      pel3_r, pal3_r, pel3_nxt, pal3_nxt;
  logic signed [44:0]      peh3_r, peh3_nxt;
  logic signed [56:0]      pah3_r, pah3_nxt;
  logic signed [63:0]      sxp3_r, syp3_r, sxp3_nxt, syp3_nxt;
  logic signed [44:0]      e3_r;
  logic signed [56:0]      ab3_r;
  logic signed [57:0]      at3_r, at3_nxt;
  logic signed [45:0]      br3_r, br3_nxt;
  logic signed [POS_W-1:0] vx3_r, vy3_r;
  // G4: full products
  logic                    v4_r;
  logic signed [76:0]      e4_r, e4_nxt;
  logic signed [88:0]      a4_r, a4_nxt;
  logic signed [63:0]      sxp4_r, syp4_r, asx4_r, asy4_r, asx4_nxt, asy4_nxt;
  side_t                   side4_r, side4_nxt;
  // G5
  logic                    v5_r;
  logic signed [89:0]      ea5_r;
  logic signed [63:0]      sxp5_r, syp5_r, asx5_r, asy5_r;
  side_t                   side5_r;
  // G6
  logic                    v6_r;
  logic signed [90:0]      ea6_r, eat6_r, rr6_r, mx6_r, nmx6_r, my6_r, nmy6_r;
  side_t                   side6_r;
  // G7: edge decisions (bottom, right, top, left)
  logic                    v7_r;
  logic                    cb7_r, cr7_r, ct7_r, cl7_r;
  logic                    cb_nxt, cr_nxt, ct_nxt, cl_nxt;
  side_t                   side7_r;
  // G8: per-axis numerator
  logic                    v8_r;
  logic                    hh8_r, hv8_r;
  logic [NUM_W-1:0]        nh8_r, nv8_r, nh_nxt, nv_nxt;
  logic [REM_W-1:0]        avx8_r, avy8_r;
  // G9: divider setup
  tstage_t                 st9_r, st9_nxt;

  function automatic logic in_band(input logic signed [90:0] x,
                                   input logic signed [90:0] m,
                                   input logic signed [90:0] nm,
                                   input logic neg);
    logic r;
    if (neg) begin
      r = (x <= 0) && (x >= nm);
    end else begin
      r = (x >= 0) && (x <= m);
    end
    return r;
  endfunction

  function automatic tlane_t lane_setup(input logic hit, input logic [NUM_W-1:0] an,
                                        input logic [REM_W-1:0] ad);
    tlane_t l;
    l.hit = hit;
    l.sat = an >= (NUM_W'(ad) << SAT_SH);
    l.rem = an[SAT_SH+REM_W-1:SAT_SH];
    l.dq  = {an[SAT_SH-1:0], {FRAC_BITS{1'b0}}};
    l.dvs = ad;
    return l;
  endfunction

  always_comb begin
    xl1_nxt = (COL_W+CS_W)'(stage_i.rem) * (COL_W+CS_W)'(cell_size_x);
    yb1_nxt = (IDX_W+CS_W)'(stage_i.dq) * (IDX_W+CS_W)'(cell_size_y);

    e2_nxt  = 45'(mot1_r.pos_x) - $signed({2'b0, xl1_r});
    ab2_nxt = $signed({2'b0, yb1_r}) - 57'(mot1_r.pos_y);

    pel3_nxt = $signed({1'b0, e2_r[31:0]}) * vy2_r;
    peh3_nxt = $signed(e2_r[44:32]) * vy2_r;
    pal3_nxt = $signed({1'b0, ab2_r[31:0]}) * vx2_r;
    pah3_nxt = $signed(ab2_r[56:32]) * vx2_r;
    sxp3_nxt = $signed({1'b0, cell_size_x}) * vy2_r;
    syp3_nxt = $signed({1'b0, cell_size_y}) * vx2_r;
    at3_nxt  = 58'(ab2_r) + $signed({27'b0, cell_size_y});
    br3_nxt  = $signed({15'b0, cell_size_x}) - 46'(e2_r);

    e4_nxt   = (77'(peh3_r) <<< 32) + 77'(pel3_r);
    a4_nxt   = (89'(pah3_r) <<< 32) + 89'(pal3_r);
    asx4_nxt = vy3_r[POS_W-1] ? -sxp3_r : sxp3_r;
    asy4_nxt = vx3_r[POS_W-1] ? -syp3_r : syp3_r;
    side4_nxt.tb     = (ab3_r == '0) || (ab3_r[56] == vy3_r[POS_W-1]);
    side4_nxt.tt     = (at3_r == '0) || (at3_r[57] == vy3_r[POS_W-1]);
    side4_nxt.tl     = (e3_r == '0) || (e3_r[44] != vx3_r[POS_W-1]);
    side4_nxt.tr     = (br3_r == '0) || (br3_r[45] == vx3_r[POS_W-1]);
    side4_nxt.vx_neg = vx3_r[POS_W-1];
    side4_nxt.vy_neg = vy3_r[POS_W-1];
    side4_nxt.vx_nz  = (vx3_r != '0);
    side4_nxt.vy_nz  = (vy3_r != '0);
    side4_nxt.n_ab   = NUM_W'(ab3_r[56] ? -ab3_r : ab3_r);
    side4_nxt.n_at   = NUM_W'(at3_r[57] ? -at3_r : at3_r);
    side4_nxt.n_e    = NUM_W'(e3_r[44] ? -e3_r : e3_r);
    side4_nxt.n_br   = NUM_W'(br3_r[45] ? -br3_r : br3_r);
    side4_nxt.avx    = vx3_r[POS_W-1] ? REM_W'(-vx3_r) : REM_W'(vx3_r);
    side4_nxt.avy    = vy3_r[POS_W-1] ? REM_W'(-vy3_r) : REM_W'(vy3_r);

    // m = u * edge_length * |v| along each edge; must land in [0, |S|]
    cb_nxt = side6_r.vy_nz && (cell_size_x != '0) && side6_r.tb &&
             in_band(ea6_r, mx6_r, nmx6_r, side6_r.vy_neg);
    ct_nxt = side6_r.vy_nz && (cell_size_x != '0) && side6_r.tt &&
             in_band(eat6_r, mx6_r, nmx6_r, side6_r.vy_neg);
    cl_nxt = side6_r.vx_nz && (cell_size_y != '0) && side6_r.tl &&
             in_band(ea6_r, my6_r, nmy6_r, ~side6_r.vx_neg);
    cr_nxt = side6_r.vx_nz && (cell_size_y != '0) && side6_r.tr &&
             in_band(rr6_r, my6_r, nmy6_r, side6_r.vx_neg);

    // same divisor per axis, so the smaller numerator gives the smaller time
    if (cb7_r && ct7_r) begin
      nh_nxt = (side7_r.n_ab < side7_r.n_at) ? side7_r.n_ab : side7_r.n_at;
    end else begin
      nh_nxt = cb7_r ? side7_r.n_ab : side7_r.n_at;
    end
    if (cl7_r && cr7_r) begin
      nv_nxt = (side7_r.n_e < side7_r.n_br) ? side7_r.n_e : side7_r.n_br;
    end else begin
      nv_nxt = cl7_r ? side7_r.n_e : side7_r.n_br;
    end

    st9_nxt.valid = v8_r;
    st9_nxt.h     = lane_setup(hh8_r, nh8_r, avy8_r);
    st9_nxt.v     = lane_setup(hv8_r, nv8_r, avx8_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      st9_r.valid <= 1'b0;
    end else if (en) begin
      v1_r   <= stage_i.valid;
      xl1_r  <= xl1_nxt;
      yb1_r  <= yb1_nxt;
      mot1_r <= stage_i.mot;

      v2_r  <= v1_r;
      e2_r  <= e2_nxt;
      ab2_r <= ab2_nxt;
      vx2_r <= mot1_r.vel_x;
      vy2_r <= mot1_r.vel_y;

      v3_r   <= v2_r;
      pel3_r <= pel3_nxt;
      peh3_r <= peh3_nxt;
      pal3_r <= pal3_nxt;
      pah3_r <= pah3_nxt;
      sxp3_r <= sxp3_nxt;
      syp3_r <= syp3_nxt;
      e3_r   <= e2_r;
      ab3_r  <= ab2_r;
      at3_r  <= at3_nxt;
      br3_r  <= br3_nxt;
      vx3_r  <= vx2_r;
      vy3_r  <= vy2_r;

      v4_r    <= v3_r;
      e4_r    <= e4_nxt;
      a4_r    <= a4_nxt;
      sxp4_r  <= sxp3_r;
      syp4_r  <= syp3_r;
      asx4_r  <= asx4_nxt;
      asy4_r  <= asy4_nxt;
      side4_r <= side4_nxt;

      v5_r    <= v4_r;
      ea5_r   <= 90'(e4_r) + 90'(a4_r);
      sxp5_r  <= sxp4_r;
      syp5_r  <= syp4_r;
      asx5_r  <= asx4_r;
      asy5_r  <= asy4_r;
      side5_r <= side4_r;

      v6_r    <= v5_r;
      ea6_r   <= 91'(ea5_r);
      eat6_r  <= 91'(ea5_r) + 91'(syp5_r);
      rr6_r   <= 91'(sxp5_r) - 91'(ea5_r);
      mx6_r   <= 91'(asx5_r);
      nmx6_r  <= -91'(asx5_r);
      my6_r   <= 91'(asy5_r);
      nmy6_r  <= -91'(asy5_r);
      side6_r <= side5_r;

      v7_r    <= v6_r;
      cb7_r   <= cb_nxt;
      cr7_r   <= cr_nxt;
      ct7_r   <= ct_nxt;
      cl7_r   <= cl_nxt;
      side7_r <= side6_r;

      v8_r   <= v7_r;
      hh8_r  <= cb7_r | ct7_r;
      hv8_r  <= cl7_r | cr7_r;
      nh8_r  <= nh_nxt;
      nv8_r  <= nv_nxt;
      avx8_r <= side7_r.avx;
      avy8_r <= side7_r.avy;

      st9_r <= st9_nxt;
    end
  end

  assign stage_o = st9_r;

endmodule

// ===== hdl/ray_cell_collision_time.sv =====
// Top level of the ray/cell collision time block.
// Depends on rcct_pkg, rcct_idx_cell, rcct_geom and rcct_time_cell.
`timescale 1ns / 1ps

// Takes a particle (cell index, Q16.16 position and velocity) and returns the
// earliest time at which it meets an edge of that grid cell, plus a hit flag;
// with no hit the time reads all ones. One transfer in per cycle while
// in_stall is low, one result per item, in order. The pipe has 24
// index-divider cells (one quotient bit of index / grid_width each), 9
// geometry stages (corner multiply, 32-bit partial products of the exact
// cross products, edge tests, divider setup), 31 time-divider cells (one
// quotient bit each for the horizontal and vertical lanes), and the output
// register. The whole pipe moves as one; it holds only while a result sits
// in the output register under out_stall. Configuration registers are read
// live, so write them only while no item is in flight.
module ray_cell_collision_time import rcct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CS_W-1:0]      cfg_data
);

  logic [CS_W-1:0] cell_size_x_r;
  logic [CS_W-1:0] cell_size_y_r;
  logic [GW_W-1:0] grid_width_r;
  logic [GW_W-1:0] gw_eff;
  logic            adv;

  idx_stage_t idx_s [0:IDX_W];
  tstage_t    tim_s [0:TIME_W];

  logic            out_valid_r;
  out_item_t       out_data_r, out_data_nxt;
  logic [TIME_W-1:0] th, tv;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_x_r <= CS_W'(1 << FRAC_BITS);
      cell_size_y_r <= CS_W'(1 << FRAC_BITS);
      grid_width_r  <= GW_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CELL_SIZE_X: cell_size_x_r <= cfg_data;
        CFG_CELL_SIZE_Y: cell_size_y_r <= cfg_data;
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_data[GW_W-1:0];
        default: ;
      endcase
    end
  end

  // zero width acts as one; wider than the max clamps
  always_comb begin
    if (grid_width_r == '0) begin
      gw_eff = GW_W'(1);
    end else if (grid_width_r > GW_W'(MAX_GRID_WIDTH)) begin
      gw_eff = GW_W'(MAX_GRID_WIDTH);
    end else begin
      gw_eff = grid_width_r;
    end
  end

  // pipe advances unless a finished result is held
  assign adv      = ~out_valid_r | ~out_stall;
  assign in_stall = ~adv;

  always_comb begin
    idx_s[0].valid     = in_valid;
    idx_s[0].rem       = '0;
    idx_s[0].dq        = in_data.cell_index;
    idx_s[0].mot.pos_x = in_data.pos_x;
    idx_s[0].mot.pos_y = in_data.pos_y;
    idx_s[0].mot.vel_x = in_data.vel_x;
    idx_s[0].mot.vel_y = in_data.vel_y;
  end

  // row = index / width lands in dq, column in rem
  for (genvar i = 0; i < IDX_W; i++) begin : g_idx
    rcct_idx_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .divisor (gw_eff),
      .stage_i (idx_s[i]),
      .stage_o (idx_s[i+1])
    );
  end

  rcct_geom u_geom (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .cell_size_x (cell_size_x_r),
    .cell_size_y (cell_size_y_r),
    .stage_i     (idx_s[IDX_W]),
    .stage_o     (tim_s[0])
  );

  for (genvar j = 0; j < TIME_W; j++) begin : g_tim
    rcct_time_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .stage_i (tim_s[j]),
      .stage_o (tim_s[j+1])
    );
  end

  // saturate each lane, then keep the earlier of the lanes that hit
  always_comb begin
    th = tim_s[TIME_W].h.sat ? TIME_MAX : tim_s[TIME_W].h.dq;
    tv = tim_s[TIME_W].v.sat ? TIME_MAX : tim_s[TIME_W].v.dq;
    out_data_nxt.hit = tim_s[TIME_W].h.hit | tim_s[TIME_W].v.hit;
    if (tim_s[TIME_W].h.hit && tim_s[TIME_W].v.hit) begin
      out_data_nxt.hit_time = (th < tv) ? th : tv;
    end else if (tim_s[TIME_W].h.hit) begin
      out_data_nxt.hit_time = th;
    end else if (tim_s[TIME_W].v.hit) begin
      out_data_nxt.hit_time = tv;
    end else begin
      out_data_nxt.hit_time = TIME_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tim_s[TIME_W].valid;
      out_data_r  <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
